// ===== rtl/uer_pkg.sv =====
// Package for the ultrasonic echo ranger: widths, reset values, codes and types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package uer_pkg;

	// Defaults for the top level's parameters
	localparam int TRIG_LOW_TICKS_DEF  = 2;
	localparam int TRIG_HIGH_TICKS_DEF = 10;
	localparam int COUNT_BITS_DEF      = 20;

	// Field and register widths
	localparam int TIMEOUT_W  = 20;
	localparam int SCALE_W    = 18;
	localparam int DIST_W     = 21;
	localparam int PULSE_W    = 20;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 20;

	// Distance is (pulse * scale) >> Q_SHIFT, scale being an unsigned Q16 value
	localparam int Q_SHIFT = 16;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// Configuration register reset values
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd30000;
	localparam logic [SCALE_W-1:0]   SCALE_RST   = 18'd111411;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 1'b1;

	// Outcome codes
	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_TO_HIGH = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_TO_LOW  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_UNUSED  = 2'd3;

	// Measurement sequencer phases
	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_TLOW  = 5'b00010,
		PH_THIGH = 5'b00100,
		PH_WHIGH = 5'b01000,
		PH_WLOW  = 5'b10000
	} phase_t;

	// Per-tick flags handed from the sequencer stage to the output stage
	typedef struct packed {
		logic                trig;
		logic                busy;
		logic                done;
		logic                ok;
		logic [STATUS_W-1:0] status;
	} uer_flags_t;

endpackage

`default_nettype wire

// ===== rtl/uer_if.sv =====
// Valid/ready channel interfaces of the ultrasonic echo ranger: ticks in,
// results out and configuration writes. Depends on uer_pkg.
`default_nettype none

interface uer_in_if;
	logic valid;
	logic ready;
	logic start_req;
	logic echo_level;
	modport source (output valid, output start_req, output echo_level, input ready);
	modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_out_if import uer_pkg::*; ;
	logic                valid;
	logic                ready;
	logic                trigger_out;
	logic                busy_res;
	logic                done_res;
	logic [STATUS_W-1:0] status;
	logic [DIST_W-1:0]   distance_centi_cm;
	logic [PULSE_W-1:0]  pulse_width_us;
	modport source (output valid, output trigger_out, output busy_res, output done_res,
		output status, output distance_centi_cm, output pulse_width_us, input ready);
	modport sink   (input valid, input trigger_out, input busy_res, input done_res,
		input status, input distance_centi_cm, input pulse_width_us, output ready);
endinterface

interface uer_cfg_if import uer_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/uer_ctrl.sv =====
// Measurement sequencer: trigger pulse, echo waits and tick counting, one tick
// per request, registered into stage 1. Depends on uer_pkg and uer_if.
`default_nettype none

module uer_ctrl import uer_pkg::*; #(
	parameter int TRIG_LOW_TICKS  = TRIG_LOW_TICKS_DEF,
	parameter int TRIG_HIGH_TICKS = TRIG_HIGH_TICKS_DEF,
	parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	uer_in_if.sink                     item,
	input  wire logic [TIMEOUT_W-1:0]  tmo_limit,
	input  wire logic                  adv,
	output      logic                  valid_s1,
	output      uer_flags_t            flags_s1,
	output      logic [COUNT_BITS-1:0] count_s1
);

	localparam int CW    = COUNT_BITS;
	localparam int CMP_W = 33;
	localparam logic [CW-1:0] CNT_MAX = '1;

	phase_t          phase_q;
	logic [CW-1:0]   count_q;
	logic            acc;
	logic            start_eff;
	phase_t          ph;
	phase_t          ph_n;
	logic [CW-1:0]   cnt;
	logic [CW-1:0]   cnt_n;
	logic [CW-1:0]   cnt_inc;
	logic            over_cur;
	logic            over_inc;
	uer_flags_t      flags;

	// Stage 1 frees up whenever the output stage takes its request
	assign item.ready = !valid_s1 || adv;
	assign acc        = item.valid && item.ready;

	// Next phase and outputs for this tick
	always_comb begin
		// an unknown phase code counts as idle
		start_eff = item.start_req &&
			!(phase_q inside {PH_TLOW, PH_THIGH, PH_WHIGH, PH_WLOW});
		ph        = start_eff ? PH_TLOW : phase_q;
		cnt       = start_eff ? '0 : count_q;
		cnt_inc   = (cnt != CNT_MAX) ? cnt + 1'b1 : cnt;
		over_cur  = (CMP_W'(cnt) > CMP_W'(tmo_limit)) || (cnt == CNT_MAX);
		over_inc  = (CMP_W'(cnt_inc) > CMP_W'(tmo_limit)) || (cnt_inc == CNT_MAX);

		ph_n         = ph;
		cnt_n        = cnt;
		flags.trig   = 1'b0;
		flags.done   = 1'b0;
		flags.ok     = 1'b0;
		flags.status = STAT_OK;

		case (ph)
			PH_TLOW: begin
				cnt_n = cnt_inc;
				if (cnt_inc >= CW'(TRIG_LOW_TICKS)) begin
					ph_n  = PH_THIGH;
					cnt_n = '0;
				end
			end
			PH_THIGH: begin
				flags.trig = 1'b1;
				cnt_n      = cnt_inc;
				if (cnt_inc >= CW'(TRIG_HIGH_TICKS)) begin
					ph_n  = PH_WHIGH;
					cnt_n = '0;
				end
			end
			PH_WHIGH: begin
				if (item.echo_level) begin
					ph_n  = PH_WLOW;
					cnt_n = '0;
				end else if (over_cur) begin
					flags.status = STAT_TO_HIGH;
					flags.done   = 1'b1;
					ph_n         = PH_IDLE;
					cnt_n        = '0;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			PH_WLOW: begin
				cnt_n = cnt_inc;
				if (!item.echo_level) begin
					flags.ok   = 1'b1;
					flags.done = 1'b1;
					ph_n       = PH_IDLE;
					cnt_n      = '0;
				end else if (over_inc) begin
					flags.status = STAT_TO_LOW;
					flags.done   = 1'b1;
					ph_n         = PH_IDLE;
					cnt_n        = '0;
				end
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase

		flags.busy = (ph_n != PH_IDLE);
	end

	// Sequencer state and stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (acc) begin
				phase_q <= ph_n;
				count_q <= cnt_n;
			end
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
		end
	end

	// Stage 1 payload: flags and the finished pulse length
	always_ff @(posedge clk) begin
		if (acc) begin
			flags_s1 <= flags;
			count_s1 <= cnt_inc;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/uer_out.sv =====
// Output stage: scales the pulse to a distance, keeps the last outcome and
// holds the result request for the sink. Depends on uer_pkg and uer_if.
`default_nettype none

module uer_out import uer_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  valid_s1,
	input  wire uer_flags_t            flags_s1,
	input  wire logic [COUNT_BITS-1:0] count_s1,
	input  wire logic [SCALE_W-1:0]    scale_factor,
	output      logic                  adv,
	uer_out_if.source                  result
);

	localparam int PW = COUNT_BITS + SCALE_W;

	logic                out_v_q;
	logic                trig_q;
	logic                busy_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [DIST_W-1:0]   dist_q;
	logic [PULSE_W-1:0]  pulse_q;
	logic [PW-1:0]       prod;
	logic [PW-1:0]       prod_sh;
	logic [DIST_W-1:0]   dist_sat;

	assign adv = !out_v_q || result.ready;

	// Q16 scaling with saturation to the distance field
	always_comb begin
		prod     = PW'(count_s1) * PW'(scale_factor);
		prod_sh  = prod >> Q_SHIFT;
		dist_sat = (prod_sh > PW'(DIST_MAX)) ? DIST_MAX : DIST_W'(prod_sh);
	end

	// Result valid and the last-outcome registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			status_q <= STAT_OK;
			dist_q   <= '0;
			pulse_q  <= '0;
		end else if (adv) begin
			out_v_q <= valid_s1;
			if (valid_s1 && flags_s1.done) begin
				status_q <= flags_s1.status;
			end
			if (valid_s1 && flags_s1.ok) begin
				dist_q  <= dist_sat;
				pulse_q <= PULSE_W'(count_s1);
			end
		end
	end

	// Per-tick flags
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			trig_q <= flags_s1.trig;
			busy_q <= flags_s1.busy;
			done_q <= flags_s1.done;
		end
	end

	assign result.valid             = out_v_q;
	assign result.trigger_out       = trig_q;
	assign result.busy_res          = busy_q;
	assign result.done_res          = done_q;
	assign result.status            = status_q;
	assign result.distance_centi_cm = dist_q;
	assign result.pulse_width_us    = pulse_q;

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger_top.sv =====
// Ultrasonic echo ranger, top level: configuration registers, sequencer and
// output stage. Depends on uer_pkg, uer_if, uer_ctrl and uer_out.
//
// Use: every request on the item channel is one microsecond tick carrying a
// start request and the sampled echo level. Each accepted tick yields exactly
// one request on the result channel: the trigger level for that tick, busy,
// done, and the last outcome (status, distance in hundredths of a cm, pulse
// width in ticks).
// A result passes the sequencer register, then the output register with the
// scaling multiplier, once its tick is accepted.
// Throughput: one tick per cycle while the sink keeps up; the sequencer state
// advances in the cycle a tick is accepted, so ticks may come back to back.
// Stalls: while the result sink holds ready low, the waiting result is kept
// and one further tick is taken into the sequencer stage; after that item
// ready drops until the result moves on.
// Configuration: index 0 is the timeout, index 1 the Q16 scale; writes are
// always taken. Reset puts the sequencer in idle, restores the register
// defaults and clears the last outcome to zero distance, zero pulse, ok.
`default_nettype none

module ultrasonic_echo_ranger_top import uer_pkg::*; #(
	parameter int TRIG_LOW_TICKS  = TRIG_LOW_TICKS_DEF,
	parameter int TRIG_HIGH_TICKS = TRIG_HIGH_TICKS_DEF,
	parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	uer_in_if.sink    item,
	uer_out_if.source result,
	uer_cfg_if.sink   cfg
);

	logic [TIMEOUT_W-1:0]  timeout_q;
	logic [SCALE_W-1:0]    scale_q;
	logic                  adv;
	logic                  valid_s1;
	uer_flags_t            flags_s1;
	logic [COUNT_BITS-1:0] count_s1;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			scale_q   <= SCALE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_TIMEOUT: timeout_q <= cfg.data[TIMEOUT_W-1:0];
				CFG_SCALE:   scale_q   <= cfg.data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	uer_ctrl #(
		.TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
		.TRIG_HIGH_TICKS (TRIG_HIGH_TICKS),
		.COUNT_BITS      (COUNT_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.tmo_limit  (timeout_q),
		.adv        (adv),
		.valid_s1   (valid_s1),
		.flags_s1   (flags_s1),
		.count_s1   (count_s1)
	);

	uer_out #(
		.COUNT_BITS (COUNT_BITS)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.flags_s1     (flags_s1),
		.count_s1     (count_s1),
		.scale_factor (scale_q),
		.adv          (adv),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== rtl/uer_check.sv =====
// Port-level checks of the ultrasonic echo ranger's result channel, bound to
// the top level. Depends on uer_pkg.
`default_nettype none

module uer_check import uer_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire logic                trigger_out,
	input wire logic                busy_res,
	input wire logic                done_res,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [DIST_W-1:0]   distance,
	input wire logic [PULSE_W-1:0]  pulse
);

	// A stalled result keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(trigger_out) &&
		$stable(busy_res) && $stable(done_res) && $stable(status) &&
		$stable(distance) && $stable(pulse))
		else $error("result changed while stalled");

	// The tick that ends a measurement leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// The trigger is only driven high mid-measurement
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && trigger_out |-> busy_res && !done_res)
		else $error("trigger high outside a measurement");

	// The spare outcome code never shows
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status != STAT_UNUSED)
		else $error("invalid status code");

endmodule

bind ultrasonic_echo_ranger_top uer_check u_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.trigger_out (result.trigger_out),
	.busy_res    (result.busy_res),
	.done_res    (result.done_res),
	.status      (result.status),
	.distance    (result.distance_centi_cm),
	.pulse       (result.pulse_width_us)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for ultrasonic_echo_ranger_top: drives microsecond ticks,
// predicts every per-tick result and checks it field by field.
// Depends on uer_pkg, the channel interfaces in uer_if and the ranger RTL.
`timescale 1ns / 1ps

module testbench import uer_pkg::*; ;

	localparam int unsigned RUN_LIMIT = 2_000_000;
	localparam int unsigned TRIG_TICKS = TRIG_LOW_TICKS_DEF + TRIG_HIGH_TICKS_DEF;
	localparam logic [COUNT_BITS_DEF-1:0] CNT_MAX = '1;
	localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
	localparam int unsigned TIMEOUT_MAX = 1_000_000;

	// One result request as seen on the result channel
	typedef struct packed {
		logic                trig;
		logic                busy;
		logic                done;
		logic [STATUS_W-1:0] status;
		logic [DIST_W-1:0]   distance;
		logic [PULSE_W-1:0]  pulse;
	} ranger_result_t;

	// Tick-by-tick prediction of the ranger and queue of pending results
	class ranger_scoreboard;
		logic [TIMEOUT_W-1:0]      tmo;
		logic [SCALE_W-1:0]        scale;
		phase_t                    seq_phase;
		logic [COUNT_BITS_DEF-1:0] cnt;
		logic [DIST_W-1:0]         last_dist;
		logic [PULSE_W-1:0]        pulse;
		logic [STATUS_W-1:0]       status;
		ranger_result_t            pending_results[$];
		int unsigned               errors;
		int unsigned               checked;
		int unsigned               n_ok, n_to_high, n_to_low;

		function new();
			tmo       = TIMEOUT_RST;
			scale     = SCALE_RST;
			seq_phase = PH_IDLE;
			cnt       = '0;
			last_dist = '0;
			pulse     = '0;
			status    = STAT_OK;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_TIMEOUT)
				tmo = data[TIMEOUT_W-1:0];
			else
				scale = data[SCALE_W-1:0];
		endfunction

		// Advance the predicted sequencer by one accepted tick
		function void note_tick(bit start, bit echo);
			logic [PULSE_W+SCALE_W-1:0]         prod;
			logic [PULSE_W+SCALE_W-Q_SHIFT-1:0] scaled;
			ranger_result_t                     r;
			bit                                 trig;
			bit                                 done;
			trig = 1'b0;
			done = 1'b0;
			if (seq_phase == PH_IDLE && start) begin
				seq_phase = PH_TLOW;
				cnt = '0;
			end
			case (seq_phase)
				PH_TLOW: begin
					cnt++;
					if (cnt >= TRIG_LOW_TICKS_DEF) begin
						seq_phase = PH_THIGH;
						cnt = '0;
					end
				end
				PH_THIGH: begin
					trig = 1'b1;
					cnt++;
					if (cnt >= TRIG_HIGH_TICKS_DEF) begin
						seq_phase = PH_WHIGH;
						cnt = '0;
					end
				end
				PH_WHIGH: begin
					if (echo) begin
						seq_phase = PH_WLOW;
						cnt = '0;
					end else if (cnt > tmo || cnt == CNT_MAX) begin
						status = STAT_TO_HIGH;
						done = 1'b1;
						n_to_high++;
						seq_phase = PH_IDLE;
						cnt = '0;
					end else begin
						cnt++;
					end
				end
				PH_WLOW: begin
					if (cnt != CNT_MAX)
						cnt++;
					if (!echo) begin
						prod      = cnt * scale;
						scaled    = prod >> Q_SHIFT;
						last_dist = (scaled > DIST_MAX) ? DIST_MAX : scaled[DIST_W-1:0];
						pulse     = cnt;
						status    = STAT_OK;
						done = 1'b1;
						n_ok++;
						seq_phase = PH_IDLE;
						cnt = '0;
					end else if (cnt > tmo || cnt == CNT_MAX) begin
						status = STAT_TO_LOW;
						done = 1'b1;
						n_to_low++;
						seq_phase = PH_IDLE;
						cnt = '0;
					end
				end
				default: ;
			endcase
			r.trig     = trig;
			r.busy     = (seq_phase != PH_IDLE);
			r.done     = done;
			r.status   = status;
			r.distance = last_dist;
			r.pulse    = pulse;
			pending_results.push_back(r);
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= 30)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task field_check(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("result %0d %s got %0h expected %0h", checked, name, got, want));
		endtask

		task check_result(ranger_result_t got);
			ranger_result_t want;
			if (pending_results.size() == 0) begin
				report("result request with nothing expected");
				return;
			end
			want = pending_results.pop_front();
			field_check("trigger_out", got.trig, want.trig);
			field_check("busy_res", got.busy, want.busy);
			field_check("done_res", got.done, want.done);
			field_check("status", got.status, want.status);
			field_check("distance_centi_cm", got.distance, want.distance);
			field_check("pulse_width_us", got.pulse, want.pulse);
			checked++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet;
	int unsigned cycles;
	int unsigned ticks_sent;
	int unsigned measurements;
	ranger_scoreboard sb;

	uer_in_if  item_ch();
	uer_out_if result_ch();
	uer_cfg_if cfg_ch();

	ultrasonic_echo_ranger_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding",
				cycles, sb.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Mostly no pause or a short one, now and then a long one; none while quiet
	function automatic int unsigned pause_len();
		int unsigned r;
		r = $urandom_range(99);
		if (quiet || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result sink: random back-pressure
	initial begin
		int unsigned g;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			g = pause_len();
			if (g > 0) begin
				result_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result({result_ch.trigger_out, result_ch.busy_res, result_ch.done_res,
				result_ch.status, result_ch.distance_centi_cm, result_ch.pulse_width_us});
	end

	// One tick request; returns on the edge at which it is taken
	task automatic send_tick(bit start, bit echo);
		int unsigned g;
		g = pause_len();
		if (g > 0) begin
			item_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.start_req  <= start;
		item_ch.echo_level <= echo;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_tick(start, echo);
		ticks_sent++;
	endtask

	// Stop sending and wait until every predicted result has come back
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One configuration request; valid is left high for the caller to drop
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, data);
	endtask

	task automatic set_regs(int unsigned tmo, int unsigned scale);
		drain();
		write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
		write_reg(CFG_SCALE, CFG_DATA_W'(scale));
		cfg_ch.valid <= 1'b0;
	endtask

	// Start, trigger ticks with stray starts and echo noise, then the echo
	task automatic measure(int unsigned wait_len, int unsigned high_len, bit start_at_end);
		send_tick(1'b1, 1'($urandom));
		repeat (TRIG_TICKS - 1) send_tick(1'($urandom), 1'($urandom));
		repeat (wait_len) send_tick(1'b0, 1'b0);
		repeat (high_len) send_tick(1'b0, 1'b1);
		send_tick(start_at_end, 1'b0);
		measurements++;
	endtask

	task automatic random_phase(int unsigned tmo, int unsigned scale, bit with_hold);
		int unsigned first;
		int unsigned lim;
		int unsigned r;
		bit          held;
		set_regs(tmo, scale);
		first = ticks_sent;
		held = 1'b0;
		lim = (tmo <= 64) ? tmo + 3 : 40;
		while (ticks_sent - first < 100) begin
			// hold off the sender until the block has caught up
			if (with_hold && !held && ticks_sent - first >= 50) begin
				drain();
				held = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 78) begin
				measure($urandom_range(0, (tmo <= 64) ? lim : 20), $urandom_range(1, lim),
					1'($urandom));
			end else if (r < 90) begin
				repeat ($urandom_range(1, 8)) send_tick(1'($urandom), 1'($urandom));
			end else begin
				// abandoned sequence: start, then echo noise
				send_tick(1'b1, 1'($urandom));
				repeat ($urandom_range(1, 20)) send_tick(1'b0, 1'($urandom));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n             <= 1'b0;
		item_ch.valid      <= 1'b0;
		item_ch.start_req  <= 1'b0;
		item_ch.echo_level <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= CFG_TIMEOUT;
		cfg_ch.data        <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: idle ticks, start on the finishing tick, short pulses
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		measure(0, 3, 1'b1);
		measure(2, 1, 1'b0);

		// Lowest settings: both waits time out, shortest good pulse
		set_regs(0, 0);
		measure(5, 0, 1'b0);
		send_tick(1'b0, 1'b1);
		measure(0, 2, 1'b0);
		measure(0, 1, 1'b0);

		// High settings: timeout 1000000 and the largest scale, back to back
		set_regs(TIMEOUT_MAX, SCALE_MAX);
		quiet = 1'b1;
		measure(1, 300, 1'b0);
		quiet = 1'b0;
		measure(3, 7, 1'b0);

		// Random phases under a range of settings
		for (int p = 0; p < 8; p++) begin
			quiet = (p == 5);
			case (p)
				0: random_phase($urandom_range(0, 12), $urandom_range(0, SCALE_MAX), 1'b0);
				2: random_phase(524_287, $urandom_range(0, SCALE_MAX), 1'b0);
				3: random_phase($urandom_range(0, 40), $urandom_range(0, SCALE_MAX), 1'b1);
				4: random_phase($urandom_range(64, TIMEOUT_MAX), 1, 1'b0);
				6: random_phase(1, SCALE_MAX, 1'b0);
				default: random_phase($urandom_range(0, 40), $urandom_range(0, SCALE_MAX), 1'b0);
			endcase
		end
		quiet = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		$display("covered %0d ticks, %0d measurement sequences, %0d results checked",
			ticks_sent, measurements, sb.checked);
		$display("outcomes: %0d ok, %0d echo-rise timeouts, %0d echo-fall timeouts, %0d errors",
			sb.n_ok, sb.n_to_high, sb.n_to_low, sb.errors);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/uer_pkg.sv
rtl/uer_if.sv
rtl/uer_ctrl.sv
rtl/uer_out.sv
rtl/ultrasonic_echo_ranger_top.sv
rtl/uer_check.sv
tb/sv/testbench.sv
